// ===== src/mtdq_pkg.sv =====
package mtdq_pkg;

  localparam int TIME_W         = 48;
  localparam int ID_W           = 32;
  localparam int DUR_W          = 32;
  localparam int MAX_TIMERS_DEF = 16;
  localparam int RES_LIMIT      = 16;
  localparam int RES_IW         = 4;
  localparam int RES_CW         = 5;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CREATE,
    OP_FIRE_NOW,
    OP_DELETE,
    OP_TICK
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   timer_id;
    logic [DUR_W-1:0]  duration_ms;
    logic [TIME_W-1:0] start_time_ms;
    logic              repeat_req;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic              fired_valid;
    logic [ID_W-1:0]   fired_id;
    logic              last_result;
    logic              queue_empty;
    logic [TIME_W-1:0] next_deadline;
    logic              table_full;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   timer_id;
    logic [DUR_W-1:0]  period;
    logic [TIME_W-1:0] deadline;
    logic              repeat_req;
    logic [TIME_W-1:0] now_ms;
  } cmd_t;

  function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
                                                input logic [DUR_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W + 1 - DUR_W){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

// ===== src/mtdq_front.sv =====
module mtdq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mtdq_pkg::in_item_t in_data,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output mtdq_pkg::cmd_t     cmd_data
);

  localparam int QW = $clog2(mtdq_pkg::QUEUE_DEPTH);

  mtdq_pkg::cmd_t q_r [mtdq_pkg::QUEUE_DEPTH];
  logic [QW-1:0]  wp_r, rp_r;
  logic [QW:0]    cnt_r;
  mtdq_pkg::cmd_t cls;
  logic           push, pop;

  // classify the request
  always_comb begin
    cls.timer_id   = in_data.timer_id;
    cls.period     = in_data.duration_ms;
    cls.deadline   = mtdq_pkg::add_sat(in_data.start_time_ms, in_data.duration_ms);
    cls.repeat_req = in_data.repeat_req;
    cls.now_ms     = in_data.now_ms;
    unique case (in_data.kind)
      mtdq_pkg::KIND_CREATE: begin
        cls.op = (in_data.duration_ms == '0 && !in_data.repeat_req) ?
                 mtdq_pkg::OP_FIRE_NOW : mtdq_pkg::OP_CREATE;
      end
      mtdq_pkg::KIND_DELETE: cls.op = mtdq_pkg::OP_DELETE;
      mtdq_pkg::KIND_TICK:   cls.op = mtdq_pkg::OP_TICK;
      default:               cls.op = mtdq_pkg::OP_NOP;
    endcase
  end

  assign in_ready  = (cnt_r != (QW+1)'(mtdq_pkg::QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd_data  = q_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

endmodule

// ===== src/mtdq_back.sv =====
module mtdq_back #(
  parameter int MAX_TIMERS = mtdq_pkg::MAX_TIMERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  mtdq_pkg::cmd_t      cmd_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mtdq_pkg::out_item_t out_data
);

  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);

  logic [mtdq_pkg::ID_W-1:0]   mem_id  [MAX_TIMERS];
  logic [mtdq_pkg::TIME_W-1:0] mem_dl  [MAX_TIMERS];
  logic [mtdq_pkg::DUR_W-1:0]  mem_per [MAX_TIMERS];
  logic                        mem_rep [MAX_TIMERS];
  logic [MAX_TIMERS-1:0]       valid_r;

  mtdq_pkg::state_t st_r, st_nxt;
  mtdq_pkg::cmd_t   cmd_r;

  logic [CW-1:0]               scan_cnt_r;
  logic                        pv_r;
  logic [IW-1:0]               rd_idx_r;
  logic [mtdq_pkg::ID_W-1:0]   rd_id_r;
  logic [mtdq_pkg::TIME_W-1:0] rd_dl_r;
  logic [mtdq_pkg::DUR_W-1:0]  rd_per_r;
  logic                        rd_rep_r;

  logic                        best_f_r;
  logic [IW-1:0]               best_idx_r;
  logic [mtdq_pkg::ID_W-1:0]   best_id_r;
  logic [mtdq_pkg::TIME_W-1:0] best_dl_r;
  logic [mtdq_pkg::DUR_W-1:0]  best_per_r;
  logic                        best_rep_r;

  logic [mtdq_pkg::ID_W-1:0]   res_id_r [mtdq_pkg::RES_LIMIT];
  logic [mtdq_pkg::RES_CW-1:0] res_cnt_r, emit_idx_r, emit_total;
  logic                        full_r;

  mtdq_pkg::out_item_t out_r;
  logic                out_valid_r;

  logic          free_f;
  logic [IW-1:0] free_idx;
  logic          scan_done, fire, out_load, emit_last, del_hit, cand, better;

  always_comb begin
    free_f   = 1'b0;
    free_idx = '0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_f   = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign scan_done  = (scan_cnt_r == CW'(MAX_TIMERS)) && !pv_r;
  assign fire       = (cmd_r.op == mtdq_pkg::OP_TICK) && best_f_r &&
                      (best_dl_r < cmd_r.now_ms) &&
                      (res_cnt_r < mtdq_pkg::RES_CW'(mtdq_pkg::RES_LIMIT));
  assign out_load   = !out_valid_r || out_ready;
  assign emit_total = (res_cnt_r == '0) ? mtdq_pkg::RES_CW'(1) : res_cnt_r;
  assign emit_last  = (emit_idx_r == emit_total - 1'b1);
  assign del_hit    = (cmd_r.op == mtdq_pkg::OP_DELETE) && (rd_id_r == cmd_r.timer_id);
  assign cand       = pv_r && valid_r[rd_idx_r] && !del_hit;
  assign better     = !best_f_r || (rd_dl_r < best_dl_r) ||
                      ((rd_dl_r == best_dl_r) && (rd_id_r < best_id_r));

  always_comb begin
    st_nxt    = st_r;
    cmd_ready = 1'b0;
    unique case (st_r)
      mtdq_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) st_nxt = mtdq_pkg::ST_SCAN;
      end
      mtdq_pkg::ST_SCAN: begin
        if (scan_done) st_nxt = mtdq_pkg::ST_DECIDE;
      end
      mtdq_pkg::ST_DECIDE: begin
        st_nxt = fire ? mtdq_pkg::ST_SCAN : mtdq_pkg::ST_EMIT;
      end
      mtdq_pkg::ST_EMIT: begin
        if (out_load && emit_last) st_nxt = mtdq_pkg::ST_IDLE;
      end
      default: st_nxt = mtdq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mtdq_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // table storage
  always_ff @(posedge clk) begin
    if (st_r == mtdq_pkg::ST_IDLE && cmd_valid &&
        cmd_data.op == mtdq_pkg::OP_CREATE && free_f) begin
      mem_id[free_idx]  <= cmd_data.timer_id;
      mem_dl[free_idx]  <= cmd_data.deadline;
      mem_per[free_idx] <= cmd_data.period;
      mem_rep[free_idx] <= cmd_data.repeat_req;
    end else if (st_r == mtdq_pkg::ST_DECIDE && fire && best_rep_r) begin
      mem_dl[best_idx_r] <= mtdq_pkg::add_sat(cmd_r.now_ms, best_per_r);
    end
    if (st_r == mtdq_pkg::ST_SCAN && scan_cnt_r != CW'(MAX_TIMERS)) begin
      rd_idx_r <= scan_cnt_r[IW-1:0];
      rd_id_r  <= mem_id[scan_cnt_r[IW-1:0]];
      rd_dl_r  <= mem_dl[scan_cnt_r[IW-1:0]];
      rd_per_r <= mem_per[scan_cnt_r[IW-1:0]];
      rd_rep_r <= mem_rep[scan_cnt_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      res_cnt_r   <= '0;
      scan_cnt_r  <= '0;
      best_f_r    <= 1'b0;
      full_r      <= 1'b0;
      emit_idx_r  <= '0;
    end else begin
      if (out_ready && st_r != mtdq_pkg::ST_EMIT) out_valid_r <= 1'b0;
      unique case (st_r)
        mtdq_pkg::ST_IDLE: begin
          if (cmd_valid) begin
            cmd_r      <= cmd_data;
            res_cnt_r  <= (cmd_data.op == mtdq_pkg::OP_FIRE_NOW) ?
                          mtdq_pkg::RES_CW'(1) : '0;
            full_r     <= (cmd_data.op == mtdq_pkg::OP_CREATE) && !free_f;
            emit_idx_r <= '0;
            scan_cnt_r <= '0;
            best_f_r   <= 1'b0;
            if (cmd_data.op == mtdq_pkg::OP_FIRE_NOW) res_id_r[0] <= cmd_data.timer_id;
            if (cmd_data.op == mtdq_pkg::OP_CREATE && free_f) valid_r[free_idx] <= 1'b1;
          end
        end
        mtdq_pkg::ST_SCAN: begin
          pv_r <= (scan_cnt_r != CW'(MAX_TIMERS));
          if (scan_cnt_r != CW'(MAX_TIMERS)) scan_cnt_r <= scan_cnt_r + 1'b1;
          if (pv_r && del_hit) valid_r[rd_idx_r] <= 1'b0;
          if (cand && better) begin
            best_f_r   <= 1'b1;
            best_idx_r <= rd_idx_r;
            best_id_r  <= rd_id_r;
            best_dl_r  <= rd_dl_r;
            best_per_r <= rd_per_r;
            best_rep_r <= rd_rep_r;
          end
        end
        mtdq_pkg::ST_DECIDE: begin
          if (fire) begin
            res_id_r[res_cnt_r[mtdq_pkg::RES_IW-1:0]] <= best_id_r;
            res_cnt_r  <= res_cnt_r + 1'b1;
            scan_cnt_r <= '0;
            best_f_r   <= 1'b0;
            if (!best_rep_r) valid_r[best_idx_r] <= 1'b0;
          end
        end
        mtdq_pkg::ST_EMIT: begin
          if (out_load) begin
            out_valid_r         <= 1'b1;
            out_r.fired_valid   <= (res_cnt_r != '0);
            out_r.fired_id      <= (res_cnt_r != '0) ?
                                   res_id_r[emit_idx_r[mtdq_pkg::RES_IW-1:0]] : '0;
            out_r.last_result   <= emit_last;
            out_r.queue_empty   <= !best_f_r;
            out_r.next_deadline <= best_f_r ? best_dl_r : '0;
            out_r.table_full    <= full_r;
            emit_idx_r          <= emit_idx_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= mtdq_pkg::RES_CW'(mtdq_pkg::RES_LIMIT))
    else $error("result count overflow");

  a_oneshot_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == mtdq_pkg::ST_DECIDE && fire && !best_rep_r) |=> !valid_r[$past(best_idx_r)])
    else $error("fired one-shot still armed");

  a_full_not_fired: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.table_full) |-> !out_r.fired_valid)
    else $error("dropped create reported as fired");

  a_fire_is_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == mtdq_pkg::ST_DECIDE && fire) |-> (best_dl_r < cmd_r.now_ms))
    else $error("timer fired before due");

endmodule

// ===== src/multi_timer_deadline_queue.sv =====
// Deadline queue for up to MAX_TIMERS software timers. Requests (create, delete, tick)
// pass through a two-entry queue into an engine that walks the timer table one slot
// per cycle over a single read port. Every request ends with a closing scan that finds
// the earliest deadline, a tick adds a further scan for each timer it fires (at most 16),
// and the results then leave one at a time as out_ready accepts them.
// Results of a request appear only after the whole request is done, since each one
// reports queue_empty and next_deadline as they stand afterwards.
module multi_timer_deadline_queue #(
  parameter int MAX_TIMERS = mtdq_pkg::MAX_TIMERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mtdq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mtdq_pkg::out_item_t out_data
);

  logic           cmd_valid, cmd_ready;
  mtdq_pkg::cmd_t cmd_data;

  mtdq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data)
  );

  mtdq_back #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
